// ===== rtl/core/itm_pkg.sv =====
// Shared types and constants of the indexed timer min-heap.
package itm_pkg;

   localparam int CAPACITY = 64;
   localparam int ID_SPACE = 1024;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = $clog2(ID_SPACE);
   localparam int ID_W     = 10;
   localparam int TIME_W   = 48;
   localparam int DELAY_W  = 31;
   localparam int J_W      = IDX_W + 2;

   localparam logic [DELAY_W-1:0] WAIT_MAX = {DELAY_W{1'b1}};
   localparam logic [TIME_W-1:0]  TIME_MAX = {TIME_W{1'b1}};

   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_ADJUST = 3'd1;
   localparam logic [2:0] OP_FIRE   = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_EXPIRE = 3'd4;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0] expiry;
      logic [ID_W-1:0]   owner;
   } heap_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOK,
      ST_CHECK,
      ST_SD_RD,
      ST_SD_CMP,
      ST_SD_END,
      ST_SU_RD,
      ST_SU_CMP,
      ST_PLACE,
      ST_TOP,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/core/itm_heap_ram.sv =====
// Heap slot memory: one write port, two registered read ports.
module itm_heap_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [itm_pkg::IDX_W-1:0] wr_addr,
   input  itm_pkg::heap_entry_type   wr_data,
   input  logic [itm_pkg::IDX_W-1:0] rd_addr_a,
   input  logic [itm_pkg::IDX_W-1:0] rd_addr_b,
   output itm_pkg::heap_entry_type   rd_data_a,
   output itm_pkg::heap_entry_type   rd_data_b
);

   itm_pkg::heap_entry_type mem [itm_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== rtl/core/indexed_timer_min_heap.sv =====
// Top level of the indexed timer min-heap.
//
// Command channel: an operation (add/rearm, adjust, fire, clear, expire) is
// transferred when start is high and busy is low. busy stays high until the
// last result of that command has been shown.
// Result channel: each result is on the rsp_ ports for one cycle with
// rsp_strobe high; rsp_last marks the final result of a command. The
// receiver cannot stall; every strobe is a transfer.
// Sequence: id lookup, then sifting down one heap level per read and compare
// step or sifting up one level per read and compare step, ending the sift,
// then placing the entry, reading the heap top and showing the result. A new
// command is transferred only after the last result of the current one.
// Expire repeats the remove and sift for every due entry, one result each.
// Reset clears the entry count; the heap and the id-to-slot map need no
// clearing since an id is known only when its mapped slot is below the
// count and holds that id. Clear is a single count reset.
module indexed_timer_min_heap (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_operation,
   input  logic [itm_pkg::ID_W-1:0]      req_timer_id,
   input  logic [itm_pkg::DELAY_W-1:0]   req_delay_ms,
   input  logic [itm_pkg::TIME_W-1:0]    req_now_ms,
   output logic                          rsp_strobe,
   output logic                          rsp_fired_valid,
   output logic [itm_pkg::ID_W-1:0]      rsp_fired_id,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_pending,
   output logic [itm_pkg::DELAY_W-1:0]   rsp_next_wait_ms,
   output logic                          rsp_last
);

   itm_pkg::state_type state_ff, state_in;

   logic [2:0]                  op_ff, op_in;
   logic [itm_pkg::ID_W-1:0]    id_ff, id_in;
   logic [itm_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [itm_pkg::TIME_W-1:0]  expiry_ff, expiry_in;
   logic [itm_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [itm_pkg::IDX_W-1:0]   cur_ff, cur_in;
   logic [itm_pkg::IDX_W-1:0]   start_ff, start_in;
   itm_pkg::heap_entry_type     elem_ff, elem_in;
   logic                        fired_valid_ff, fired_valid_in;
   logic [itm_pkg::ID_W-1:0]    fired_id_ff, fired_id_in;
   logic [1:0]                  status_ff, status_in;

   // heap memory ports
   logic                        heap_we;
   logic [itm_pkg::IDX_W-1:0]   heap_wa;
   itm_pkg::heap_entry_type     heap_wd;
   logic [itm_pkg::IDX_W-1:0]   heap_ra_a, heap_ra_b;
   itm_pkg::heap_entry_type     rd_a, rd_b;

   // id-to-slot map
   logic [itm_pkg::IDX_W-1:0]   pos_mem [itm_pkg::ID_SPACE];
   logic                        pos_we;
   logic [itm_pkg::POS_W-1:0]   pos_wa, pos_ra;
   logic [itm_pkg::IDX_W-1:0]   pos_wd, pos_q;

   logic [itm_pkg::TIME_W:0]    sum_full;
   logic                        id_ok, known, due, full;
   logic                        do_rm, rm_short;
   logic [itm_pkg::IDX_W-1:0]   rm_idx;
   logic [itm_pkg::CNT_W-1:0]   count_dec;
   logic [itm_pkg::J_W-1:0]     j_left, j_right, count_x;
   logic                        right_ok, pick_right, sd_stop, su_stop;
   itm_pkg::heap_entry_type     child;
   logic [itm_pkg::IDX_W-1:0]   child_idx, parent_idx;
   logic [itm_pkg::TIME_W-1:0]  wait_diff;

   itm_heap_ram u_heap (
      .clock     (clock),
      .wr_en     (heap_we),
      .wr_addr   (heap_wa),
      .wr_data   (heap_wd),
      .rd_addr_a (heap_ra_a),
      .rd_addr_b (heap_ra_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_wa] <= pos_wd;
      end
      pos_q <= pos_mem[pos_ra];
   end

   assign pos_ra = (state_ff == itm_pkg::ST_IDLE) ? itm_pkg::POS_W'(req_timer_id)
                                                  : itm_pkg::POS_W'(id_ff);

   // shared decode
   always_comb begin
      count_x    = itm_pkg::J_W'(count_ff);
      count_dec  = count_ff - itm_pkg::CNT_W'(1);
      id_ok      = 32'(id_ff) < itm_pkg::ID_SPACE;
      known      = id_ok && (itm_pkg::J_W'(pos_q) < count_x) && (rd_a.owner == id_ff);
      full       = count_x >= itm_pkg::J_W'(itm_pkg::CAPACITY);
      due        = (count_ff != '0) && (rd_a.expiry <= now_ff);
      sum_full   = {1'b0, req_now_ms} + (itm_pkg::TIME_W + 1)'(req_delay_ms);
      j_left     = {1'b0, cur_ff, 1'b1};
      j_right    = j_left + itm_pkg::J_W'(1);
      right_ok   = j_right < count_x;
      pick_right = right_ok && (rd_b.expiry < rd_a.expiry);
      child      = pick_right ? rd_b : rd_a;
      child_idx  = pick_right ? j_right[itm_pkg::IDX_W-1:0] : j_left[itm_pkg::IDX_W-1:0];
      sd_stop    = elem_ff.expiry < child.expiry;
      parent_idx = (cur_ff - itm_pkg::IDX_W'(1)) >> 1;
      su_stop    = rd_a.expiry < elem_ff.expiry;
      do_rm      = 1'b0;
      rm_idx     = '0;
      if (state_ff == itm_pkg::ST_CHECK) begin
         if (op_ff == itm_pkg::OP_FIRE && known) begin
            do_rm  = 1'b1;
            rm_idx = pos_q;
         end else if (op_ff == itm_pkg::OP_EXPIRE && due) begin
            do_rm = 1'b1;
         end
      end else if (state_ff == itm_pkg::ST_EMIT) begin
         do_rm = (op_ff == itm_pkg::OP_EXPIRE) && fired_valid_ff && due;
      end
      rm_short = itm_pkg::CNT_W'(rm_idx) == count_dec;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itm_pkg::ST_IDLE:   if (start) state_in = itm_pkg::ST_LOOK;
         itm_pkg::ST_LOOK:   state_in = itm_pkg::ST_CHECK;
         itm_pkg::ST_CHECK: begin
            state_in = itm_pkg::ST_TOP;
            if (do_rm) begin
               state_in = rm_short ? itm_pkg::ST_TOP : itm_pkg::ST_SD_RD;
            end else if (op_ff == itm_pkg::OP_ADD && id_ok) begin
               if (known) state_in = itm_pkg::ST_SD_RD;
               else if (!full) state_in = itm_pkg::ST_SU_RD;
            end else if (op_ff == itm_pkg::OP_ADJUST && known) begin
               state_in = itm_pkg::ST_SD_RD;
            end
         end
         itm_pkg::ST_SD_RD:
            state_in = (j_left >= count_x) ? itm_pkg::ST_SD_END : itm_pkg::ST_SD_CMP;
         itm_pkg::ST_SD_CMP:
            state_in = sd_stop ? itm_pkg::ST_SD_END : itm_pkg::ST_SD_RD;
         itm_pkg::ST_SD_END:
            state_in = (cur_ff != start_ff) ? itm_pkg::ST_PLACE : itm_pkg::ST_SU_RD;
         itm_pkg::ST_SU_RD:
            state_in = (cur_ff == '0) ? itm_pkg::ST_PLACE : itm_pkg::ST_SU_CMP;
         itm_pkg::ST_SU_CMP:
            state_in = su_stop ? itm_pkg::ST_PLACE : itm_pkg::ST_SU_RD;
         itm_pkg::ST_PLACE:  state_in = itm_pkg::ST_TOP;
         itm_pkg::ST_TOP:    state_in = itm_pkg::ST_EMIT;
         itm_pkg::ST_EMIT: begin
            if (do_rm) state_in = rm_short ? itm_pkg::ST_TOP : itm_pkg::ST_SD_RD;
            else       state_in = itm_pkg::ST_IDLE;
         end
         default:            state_in = itm_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in          = op_ff;
      id_in          = id_ff;
      now_in         = now_ff;
      expiry_in      = expiry_ff;
      count_in       = count_ff;
      cur_in         = cur_ff;
      start_in       = start_ff;
      elem_in        = elem_ff;
      fired_valid_in = fired_valid_ff;
      fired_id_in    = fired_id_ff;
      status_in      = status_ff;
      heap_we        = 1'b0;
      heap_wa        = cur_ff;
      heap_wd        = elem_ff;
      heap_ra_a      = '0;
      heap_ra_b      = itm_pkg::IDX_W'(count_dec);
      pos_we         = 1'b0;
      pos_wa         = itm_pkg::POS_W'(elem_ff.owner);
      pos_wd         = cur_ff;
      rsp_strobe       = 1'b0;
      rsp_last         = 1'b0;
      rsp_pending      = count_ff != '0;
      rsp_next_wait_ms = '0;
      wait_diff        = rd_a.expiry - now_ff;

      case (state_ff)
         itm_pkg::ST_IDLE: begin
            if (start) begin
               op_in          = req_operation;
               id_in          = req_timer_id;
               now_in         = req_now_ms;
               expiry_in      = sum_full[itm_pkg::TIME_W] ? itm_pkg::TIME_MAX
                                                          : sum_full[itm_pkg::TIME_W-1:0];
               fired_valid_in = 1'b0;
               fired_id_in    = '0;
               status_in      = itm_pkg::STATUS_OK;
            end
         end
         itm_pkg::ST_LOOK: begin
            heap_ra_a = (op_ff == itm_pkg::OP_EXPIRE) ? '0 : pos_q;
         end
         itm_pkg::ST_CHECK: begin
            case (op_ff)
               itm_pkg::OP_ADD: begin
                  if (!id_ok) begin
                     status_in = itm_pkg::STATUS_UNKNOWN;
                  end else if (known) begin
                     elem_in  = '{expiry: expiry_ff, owner: id_ff};
                     cur_in   = pos_q;
                     start_in = pos_q;
                  end else if (full) begin
                     status_in = itm_pkg::STATUS_FULL;
                  end else begin
                     elem_in  = '{expiry: expiry_ff, owner: id_ff};
                     cur_in   = itm_pkg::IDX_W'(count_ff);
                     count_in = count_ff + itm_pkg::CNT_W'(1);
                  end
               end
               itm_pkg::OP_ADJUST: begin
                  if (known) begin
                     elem_in  = '{expiry: expiry_ff, owner: id_ff};
                     cur_in   = pos_q;
                     start_in = pos_q;
                  end else begin
                     status_in = itm_pkg::STATUS_UNKNOWN;
                  end
               end
               itm_pkg::OP_FIRE: begin
                  if (known) begin
                     fired_valid_in = 1'b1;
                     fired_id_in    = id_ff;
                  end else begin
                     status_in = itm_pkg::STATUS_UNKNOWN;
                  end
               end
               itm_pkg::OP_CLEAR:  count_in = '0;
               itm_pkg::OP_EXPIRE: begin
                  if (due) begin
                     fired_valid_in = 1'b1;
                     fired_id_in    = rd_a.owner;
                  end
               end
               default: ;
            endcase
         end
         itm_pkg::ST_SD_RD: begin
            heap_ra_a = j_left[itm_pkg::IDX_W-1:0];
            heap_ra_b = j_right[itm_pkg::IDX_W-1:0];
         end
         itm_pkg::ST_SD_CMP: begin
            if (!sd_stop) begin
               heap_we = 1'b1;
               heap_wd = child;
               pos_we  = 1'b1;
               pos_wa  = itm_pkg::POS_W'(child.owner);
               cur_in  = child_idx;
            end
         end
         itm_pkg::ST_SU_RD: begin
            heap_ra_a = parent_idx;
         end
         itm_pkg::ST_SU_CMP: begin
            if (!su_stop) begin
               heap_we = 1'b1;
               heap_wd = rd_a;
               pos_we  = 1'b1;
               pos_wa  = itm_pkg::POS_W'(rd_a.owner);
               cur_in  = parent_idx;
            end
         end
         itm_pkg::ST_PLACE: begin
            heap_we = 1'b1;
            pos_we  = 1'b1;
         end
         itm_pkg::ST_TOP: begin
            heap_ra_a = '0;
         end
         itm_pkg::ST_EMIT: begin
            rsp_strobe = 1'b1;
            rsp_last   = !do_rm;
            if (count_ff != '0 && rd_a.expiry > now_ff) begin
               rsp_next_wait_ms = (wait_diff > itm_pkg::TIME_W'(itm_pkg::WAIT_MAX))
                                  ? itm_pkg::WAIT_MAX : wait_diff[itm_pkg::DELAY_W-1:0];
            end
            if (do_rm) begin
               fired_id_in = rd_a.owner;
            end
         end
         default: ;
      endcase

      // remove: last slot moves into the hole, then sifts
      if (do_rm) begin
         count_in = count_dec;
         if (!rm_short) begin
            elem_in  = rd_b;
            cur_in   = rm_idx;
            start_in = rm_idx;
         end
      end
   end

   assign busy            = state_ff != itm_pkg::ST_IDLE;
   assign rsp_fired_valid = fired_valid_ff;
   assign rsp_fired_id    = fired_id_ff;
   assign rsp_status      = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itm_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff          <= op_in;
      id_ff          <= id_in;
      now_ff         <= now_in;
      expiry_ff      <= expiry_in;
      cur_ff         <= cur_in;
      start_ff       <= start_in;
      elem_ff        <= elem_in;
      fired_valid_ff <= fired_valid_in;
      fired_id_ff    <= fired_id_in;
      status_ff      <= status_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= itm_pkg::CAPACITY)
      else $error("entry count above capacity");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !busy)
      else $error("busy after final result");

   a_wait_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_pending |-> rsp_next_wait_ms == '0)
      else $error("nonzero wait with empty heap");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("command transfer not followed by busy");

endmodule
